// File: design/sha_pkg.sv
// Shared types, round constants and initial hash values for the SHA-256 core.
package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int BUF_DEP = 16;
    localparam int BUF_AW  = $clog2(BUF_DEP);

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [7:0]       t_hash;

    typedef struct packed {
        logic load;
        logic step;
        logic use_mem;
    } t_comp_ctl;

    localparam t_hash H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic t_word round_k(input logic [5:0] r);
        t_word k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// File: design/sha256_message_hasher_core.sv
// Top level of the streaming SHA-256 core: byte packing, padding, control and digest output.
// Usage: one transaction is accepted per cycle while o_ready is high; a byte that
// completes a 64-byte block holds o_ready low for compression (64 rounds, one per
// cycle from the registered read port of the block buffer, then a hash-add
// state). End of message pads one byte per cycle between compressions (up to 72
// padding bytes and one or two block compressions), then presents the eight digest
// words, one per output transaction; the core is ready for the next message after word 7.
module sha256_message_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_ADD, S_EMIT} t_state;

    t_state      r_state, n_state;
    t_hash       r_h;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [23:0] r_word;
    logic [6:0]  r_t;
    logic        r_eom, r_sent80, r_lenon, r_lenfin;
    logic [2:0]  r_lcnt, r_oidx;

    logic        put_en, n_sent80, n_lenon, n_lenfin;
    logic [7:0]  put_byte;
    logic [2:0]  n_lcnt;
    t_word       wdata;
    logic        we;
    t_word       rdata;
    t_hash       vars;
    t_comp_ctl   ctl;

    always_comb begin
        put_en   = 1'b0;
        put_byte = i_data_byte;
        n_sent80 = r_sent80;
        n_lenon  = r_lenon;
        n_lenfin = r_lenfin;
        n_lcnt   = r_lcnt;
        case (r_state)
            S_IDLE: begin
                put_en = i_valid && i_byte_present;
            end
            S_PAD: begin
                put_en = 1'b1;
                if (!r_sent80) begin
                    put_byte = PAD_BYTE;
                    n_sent80 = 1'b1;
                end else if (r_lenon) begin
                    put_byte = r_bits[8*(7-r_lcnt) +: 8];
                    n_lcnt   = r_lcnt + 3'd1;
                    n_lenfin = (r_lcnt == 3'd7);
                end else if (r_fill == LEN_START) begin
                    put_byte = r_bits[63:56];
                    n_lenon  = 1'b1;
                    n_lcnt   = 3'd1;
                end else begin
                    put_byte = 8'h00;
                end
            end
            S_EMIT: begin
                if (i_ready && r_oidx == 3'd7) begin
                    n_sent80 = 1'b0;
                    n_lenon  = 1'b0;
                    n_lenfin = 1'b0;
                    n_lcnt   = '0;
                end
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
        wdata       = {r_word, put_byte};
        we          = put_en && (r_fill[1:0] == 2'd3);
        ctl.load    = put_en && (r_fill == 6'd63);
        ctl.step    = (r_state == S_COMP) && (r_t != 7'd0);
        ctl.use_mem = (r_t <= 7'd16);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_byte_present && r_fill == 6'd63) begin
                        n_state = S_COMP;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD:  n_state = (r_fill == 6'd63) ? S_COMP : S_PAD;
            S_COMP: n_state = (r_t == 7'd64) ? S_ADD : S_COMP;
            S_ADD:  n_state = !r_eom ? S_IDLE : (r_lenfin ? S_EMIT : S_PAD);
            S_EMIT: n_state = (i_ready && r_oidx == 3'd7) ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    sha_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_fill[5:2]),
        .i_wdata (wdata),
        .i_raddr (r_t[3:0]),
        .o_rdata (rdata)
    );

    sha_comp u_comp (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_round    (r_t[5:0] - 6'd1),
        .i_hash     (r_h),
        .i_mem_data (rdata),
        .o_vars     (vars)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_h      <= H_INIT;
            r_fill   <= '0;
            r_bits   <= '0;
            r_t      <= '0;
            r_eom    <= 1'b0;
            r_sent80 <= 1'b0;
            r_lenon  <= 1'b0;
            r_lenfin <= 1'b0;
            r_lcnt   <= '0;
            r_oidx   <= '0;
        end else begin
            r_state  <= n_state;
            r_sent80 <= n_sent80;
            r_lenon  <= n_lenon;
            r_lenfin <= n_lenfin;
            r_lcnt   <= n_lcnt;
            if (put_en) begin
                r_word <= wdata[23:0];
                r_fill <= r_fill + 6'd1;
            end
            if (r_state == S_IDLE && i_valid) begin
                r_eom <= i_end_of_message;
                if (i_byte_present) begin
                    r_bits <= r_bits + 64'd8;
                end
            end
            r_t <= (r_state == S_COMP) ? r_t + 7'd1 : 7'd0;
            if (r_state == S_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + vars[i];
                end
            end
            if (r_state == S_EMIT && i_ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_h    <= H_INIT;
                    r_fill <= '0;
                    r_bits <= '0;
                    r_eom  <= 1'b0;
                end
            end
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_EMIT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input and output sides active together");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> (o_ready && r_fill == 6'd0))
        else $error("core not cleared after final digest word");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && r_t == 7'd64) |=> (r_state == S_ADD))
        else $error("compression overran its round count");
endmodule

// File: design/sha_ram.sv
// Block buffer memory: one write port, one registered read port.
module sha_ram (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [sha_pkg::BUF_AW-1:0] i_waddr,
    input  sha_pkg::t_word        i_wdata,
    input  logic [sha_pkg::BUF_AW-1:0] i_raddr,
    output sha_pkg::t_word        o_rdata
);
    import sha_pkg::*;

    t_word r_mem [BUF_DEP];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/sha_comp.sv
// Compression round unit: working variables and rolling message schedule.
module sha_comp (
    input  logic               i_clk,
    input  sha_pkg::t_comp_ctl i_ctl,
    input  logic [5:0]         i_round,
    input  sha_pkg::t_hash     i_hash,
    input  sha_pkg::t_word     i_mem_data,
    output sha_pkg::t_hash     o_vars
);
    import sha_pkg::*;

    t_hash r_v;
    t_word r_win [16];
    t_word w, s0, s1, t1, t2, w2, w15;

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    always_comb begin
        w2  = r_win[14];
        w15 = r_win[1];
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        w   = i_ctl.use_mem ? i_mem_data : (s1 + r_win[9] + s0 + r_win[0]);
        t1  = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
            + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(i_round) + w;
        t2  = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
            + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_hash;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= w;
        end
    end

    assign o_vars = r_v;
endmodule
